>>> design/ssl_pkg.sv
// shared types, constants and helpers for the servo slew limiter
// no dependencies; imported by every module of the block
package ssl_pkg;

    localparam int unsigned ANGLE_W   = 8;
    localparam int unsigned TARGET_W  = 16;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned WIDE_W    = 18;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DATA_W    = 32;

    localparam logic [ANGLE_W-1:0]   ANGLE_MAX   = 8'd180;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

    localparam logic [15:0]        RST_TIMEOUT   = 16'd500;
    localparam logic [ANGLE_W-1:0] RST_SURF_STEP = 8'd4;
    localparam logic [ANGLE_W-1:0] RST_THR_STEP  = 8'd10;
    localparam logic [ANGLE_W-1:0] RST_AIL_MAX   = 8'd120;
    localparam logic [ANGLE_W-1:0] RST_NEUTRAL   = 8'd60;

    typedef enum logic [2:0] {
        REG_TIMEOUT   = 3'd0,
        REG_SURF_STEP = 3'd1,
        REG_THR_STEP  = 3'd2,
        REG_AIL_MAX   = 3'd3,
        REG_NEUTRAL   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]        timeout_ms;
        logic [ANGLE_W-1:0] surface_step;
        logic [ANGLE_W-1:0] thrust_step;
        logic [ANGLE_W-1:0] aileron_valid_max;
        logic [ANGLE_W-1:0] neutral_position;
    } t_cfg;

    // packed so that elevator sits in the lowest bits, as on the output bus
    typedef struct packed {
        logic               link_lost;
        logic [ANGLE_W-1:0] thrust;
        logic [ANGLE_W-1:0] aileron;
        logic [ANGLE_W-1:0] rudder;
        logic [ANGLE_W-1:0] elevator;
    } t_result;

    function automatic logic [ANGLE_W-1:0] f_clamp_angle(input logic signed [WIDE_W-1:0] v);
        logic [ANGLE_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({{(WIDE_W-ANGLE_W){1'b0}}, ANGLE_MAX})) begin
            r = ANGLE_MAX;
        end else begin
            r = v[ANGLE_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> design/ssl_slew_lane.sv
// one slew lane: moves a servo position toward its target by at most one step
// depends on ssl_pkg
module ssl_slew_lane (
    input  logic signed [ssl_pkg::TARGET_W-1:0] i_target,
    input  logic        [ssl_pkg::ANGLE_W-1:0]  i_cur,
    input  logic        [ssl_pkg::ANGLE_W-1:0]  i_step,
    output logic        [ssl_pkg::ANGLE_W-1:0]  o_next
);
    import ssl_pkg::*;

    logic signed [WIDE_W-1:0] tgt;
    logic signed [WIDE_W-1:0] cur;
    logic signed [WIDE_W-1:0] stp;
    logic signed [WIDE_W-1:0] diff;
    logic signed [WIDE_W-1:0] mag;

    assign tgt  = WIDE_W'(i_target);
    assign cur  = $signed({{(WIDE_W-ANGLE_W){1'b0}}, i_cur});
    assign stp  = $signed({{(WIDE_W-ANGLE_W){1'b0}}, i_step});
    assign diff = tgt - cur;
    assign mag  = diff[WIDE_W-1] ? -diff : diff;

    always_comb begin
        if (mag < stp) begin
            o_next = f_clamp_angle(tgt);
        end else if (diff > 0) begin
            o_next = f_clamp_angle(cur + stp);
        end else if (diff < 0) begin
            o_next = f_clamp_angle(cur - stp);
        end else begin
            o_next = i_cur;
        end
    end

endmodule

>>> design/ssl_cfg_regs.sv
// configuration register file behind the apb-style port
// depends on ssl_pkg
module ssl_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssl_pkg::ADDR_W-1:0]  paddr,
    input  logic [ssl_pkg::DATA_W-1:0]  pwdata,
    output logic [ssl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ssl_pkg::t_cfg               o_cfg
);
    import ssl_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            case (idx)
                REG_TIMEOUT:   n_cfg.timeout_ms        = pwdata[15:0];
                REG_SURF_STEP: n_cfg.surface_step      = pwdata[ANGLE_W-1:0];
                REG_THR_STEP:  n_cfg.thrust_step       = pwdata[ANGLE_W-1:0];
                REG_AIL_MAX:   n_cfg.aileron_valid_max = pwdata[ANGLE_W-1:0];
                REG_NEUTRAL:   n_cfg.neutral_position  = pwdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TIMEOUT:   prdata = {16'd0, r_cfg.timeout_ms};
            REG_SURF_STEP: prdata = {24'd0, r_cfg.surface_step};
            REG_THR_STEP:  prdata = {24'd0, r_cfg.thrust_step};
            REG_AIL_MAX:   prdata = {24'd0, r_cfg.aileron_valid_max};
            REG_NEUTRAL:   prdata = {24'd0, r_cfg.neutral_position};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms        <= RST_TIMEOUT;
            r_cfg.surface_step      <= RST_SURF_STEP;
            r_cfg.thrust_step       <= RST_THR_STEP;
            r_cfg.aileron_valid_max <= RST_AIL_MAX;
            r_cfg.neutral_position  <= RST_NEUTRAL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> design/servo_slew_limiter_with_failsafe_unit.sv
// top level: four slew lanes, failsafe merge, state and a two-entry output buffer
// depends on ssl_pkg, ssl_slew_lane and ssl_cfg_regs
//
// Four-channel servo slew limiter with link-loss failsafe. Each input item is
// either a millisecond tick (tuser = 0) or a packet of four target angles
// (tuser = 1); every item produces exactly one result item with the four servo
// angles and the link-lost flag. One item is accepted per clock cycle unless
// the input stalls, and its result is registered into the output or skid
// entry; the four lanes, the elapsed counter and the timeout compare are all
// combinational; the state update loop fixes the rate at one item per cycle.
// A two-entry output buffer lets the input keep flowing while one result waits;
// the input stalls only when both entries are full. Packets whose aileron
// target lies outside 0..aileron_valid_max are dropped but still give a result.
module servo_slew_limiter_with_failsafe_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // stream input
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] elevator_target, [31:16] rudder_target,
    // [47:32] aileron_target, [63:48] thrust_target
    input  logic [63:0]                s_axis_tdata,
    // [0] mode
    input  logic                       s_axis_tuser,
    // stream output
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [7:0] elevator_out, [15:8] rudder_out, [23:16] aileron_out, [31:24] thrust_out
    output logic [31:0]                m_axis_tdata,
    // [0] link_lost
    output logic                       m_axis_tuser,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssl_pkg::ADDR_W-1:0] paddr,
    input  logic [ssl_pkg::DATA_W-1:0] pwdata,
    output logic [ssl_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import ssl_pkg::*;

    t_cfg cfg;

    logic [ANGLE_W-1:0]   r_elev, r_rud, r_ail, r_thr;
    logic [ANGLE_W-1:0]   n_elev, n_rud, n_ail, n_thr;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;

    logic [ANGLE_W-1:0] lane_elev, lane_rud, lane_ail, lane_thr;
    logic [ANGLE_W-1:0] neutral;

    logic signed [TARGET_W-1:0] tgt_elev, tgt_rud, tgt_ail, tgt_thr;

    logic    accept, pkt_ok, lost;
    t_result res;

    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    ssl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign tgt_elev = s_axis_tdata[15:0];
    assign tgt_rud  = s_axis_tdata[31:16];
    assign tgt_ail  = s_axis_tdata[47:32];
    assign tgt_thr  = s_axis_tdata[63:48];

    ssl_slew_lane u_lane_elev (
        .i_target (tgt_elev), .i_cur (r_elev), .i_step (cfg.surface_step), .o_next (lane_elev)
    );
    ssl_slew_lane u_lane_rud (
        .i_target (tgt_rud), .i_cur (r_rud), .i_step (cfg.surface_step), .o_next (lane_rud)
    );
    ssl_slew_lane u_lane_ail (
        .i_target (tgt_ail), .i_cur (r_ail), .i_step (cfg.surface_step), .o_next (lane_ail)
    );
    ssl_slew_lane u_lane_thr (
        .i_target (tgt_thr), .i_cur (r_thr), .i_step (cfg.thrust_step), .o_next (lane_thr)
    );

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // packet valid only for aileron target in 0..aileron_valid_max
    assign pkt_ok = s_axis_tuser && !tgt_ail[TARGET_W-1]
                    && (tgt_ail <= $signed({8'd0, cfg.aileron_valid_max}));

    assign neutral = f_clamp_angle($signed({{(WIDE_W-ANGLE_W){1'b0}}, cfg.neutral_position}));

    // merge: take lane results on a valid packet, then apply the failsafe
    always_comb begin
        if (pkt_ok) begin
            n_elapsed = '0;
        end else if (!s_axis_tuser && (r_elapsed != ELAPSED_MAX)) begin
            n_elapsed = r_elapsed + ELAPSED_W'(1);
        end else begin
            n_elapsed = r_elapsed;
        end

        lost = n_elapsed > {1'b0, cfg.timeout_ms};

        if (lost) begin
            n_elev = neutral;
            n_rud  = neutral;
            n_ail  = neutral;
            n_thr  = '0;
        end else if (pkt_ok) begin
            n_elev = lane_elev;
            n_rud  = lane_rud;
            n_ail  = lane_ail;
            n_thr  = lane_thr;
        end else begin
            n_elev = r_elev;
            n_rud  = r_rud;
            n_ail  = r_ail;
            n_thr  = r_thr;
        end

        res.link_lost = lost;
        res.thrust    = n_thr;
        res.aileron   = n_ail;
        res.rudder    = n_rud;
        res.elevator  = n_elev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elev    <= RST_NEUTRAL;
            r_rud     <= RST_NEUTRAL;
            r_ail     <= RST_NEUTRAL;
            r_thr     <= '0;
            r_elapsed <= '0;
        end else if (accept) begin
            r_elev    <= n_elev;
            r_rud     <= n_rud;
            r_ail     <= n_ail;
            r_thr     <= n_thr;
            r_elapsed <= n_elapsed;
        end
    end

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (m_axis_tready && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.thrust, r_out.aileron, r_out.rudder, r_out.elevator};
    assign m_axis_tuser  = r_out.link_lost;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a valid output entry");

    a_lost_zero_thrust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[31:24] == 8'd0))
        else $error("failsafe result with nonzero thrust");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_elev <= ANGLE_MAX) && (r_rud <= ANGLE_MAX) && (r_ail <= ANGLE_MAX)
        && (r_thr <= ANGLE_MAX))
        else $error("servo position beyond angle range");

    a_tick_no_decrease: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tuser) |=> (r_elapsed >= $past(r_elapsed)))
        else $error("elapsed counter fell on a tick");
`endif

endmodule
